### rtl/led_lease_handle_table_top_defines.svh
// Assertion macros for the LED lease handle table.
`ifndef LED_LEASE_HANDLE_TABLE_TOP_DEFINES_SVH
`define LED_LEASE_HANDLE_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LLHT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("llht assertion failed");
`define LLHT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("llht assertion failed");
`else
`define LLHT_ASSERT_SAME(label, clk, rstn, ante, cons)
`define LLHT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### rtl/llht_pkg.sv
// Shared constants for the LED lease handle table.
package llht_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int LED_W          = 8;
    localparam int GEN_W          = 8;
    localparam int HANDLE_W       = 32;
    localparam int OP_W           = 3;
    localparam int STAT_W         = 3;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 8;

    localparam logic [15:0] HANDLE_TAG = 16'h504c;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd2;
    localparam logic [OP_W-1:0] OP_SET     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;
    localparam logic [OP_W-1:0] OP_TOGGLE  = 3'd5;
    localparam logic [OP_W-1:0] OP_READ    = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID_ARG = 3'd1;
    localparam logic [STAT_W-1:0] STAT_UNSUPPORTED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_PRESENT = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BUSY        = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NO_SLOTS    = 3'd5;
    localparam logic [STAT_W-1:0] STAT_BAD_HANDLE  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_PRESENT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_LEDS = 4'd1;

endpackage

### rtl/led_lease_handle_table_top.sv
// LED lease handle table: slot memories, handle checks and LED data register.
//
//   channel   direction   handshake              payload
//   s_        in          s_valid / s_ready      op, handle, mask, value, shared, in_use
//   m_        out         m_valid / m_ready      status, new_handle, led_state, owned_leds
//   cfg_      in          cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each transaction runs in a read step, which reads the slot memories, and then an
// execute step, which checks, modifies and writes back. A new transaction is taken in the cycle after.
// Reset is synchronous; valid bits clear the slot table at once, no sweep.
// A result that is not taken holds the block in the write-back cycle.
`include "led_lease_handle_table_top_defines.svh"

module led_lease_handle_table_top
    import llht_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_op,
    input  logic [HANDLE_W-1:0]   s_handle,
    input  logic [LED_W-1:0]      s_mask,
    input  logic [LED_W-1:0]      s_value,
    input  logic                  s_shared_requested,
    input  logic                  s_lease_in_use,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STAT_W-1:0]     m_status,
    output logic [HANDLE_W-1:0]   m_new_handle,
    output logic [LED_W-1:0]      m_led_state,
    output logic [LED_W-1:0]      m_owned_leds,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg, state_next;
    logic                  present_reg;
    logic [LED_W-1:0]      reserved_reg;
    logic [LED_W-1:0]      own_reg, own_next;
    logic [LED_W-1:0]      led_reg, led_next;
    logic [SLOT_COUNT-1:0] in_use_reg, in_use_next;
    logic [SLOT_COUNT-1:0] gen_vld_reg, gen_vld_next;

    logic [LED_W-1:0] mask_mem [SLOT_COUNT];
    logic [GEN_W-1:0] gen_mem  [SLOT_COUNT];
    logic [LED_W-1:0] mask_rd_reg;
    logic [GEN_W-1:0] gen_rd_reg;

    logic [OP_W-1:0]   op_reg;
    logic              tag_ok_reg;
    logic [GEN_W-1:0]  hgen_reg;
    logic [LED_W-1:0]  mask_reg;
    logic [LED_W-1:0]  value_reg;
    logic              shared_reg;
    logic              lease_in_use_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              free_found_reg;

    logic                m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]   m_status_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic [LED_W-1:0]    m_led_reg;
    logic [LED_W-1:0]    m_own_reg;

    logic              accept;
    logic              fire;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [7:0]        slot_num;
    logic              num_ok;
    logic [SLOT_W-1:0] handle_idx;
    logic [SLOT_W-1:0] rd_addr;

    logic [GEN_W-1:0]    gen_cur, gen_inc, gen_new;
    logic                handle_ok;
    logic                acq_ok;
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] new_handle;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign fire      = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_new_handle = m_handle_reg;
    assign m_led_state  = m_led_reg;
    assign m_owned_leds = m_own_reg;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign slot_num   = s_handle[7:0];
    assign num_ok     = (slot_num != 8'd0) && (slot_num <= 8'(SLOT_COUNT));
    assign handle_idx = num_ok ? SLOT_W'(slot_num - 8'd1) : '0;
    assign rd_addr    = (s_op == OP_ACQUIRE) ? free_idx : handle_idx;

    always_ff @(posedge aclk) begin
        if (accept) begin
            mask_rd_reg <= mask_mem[rd_addr];
            gen_rd_reg  <= gen_mem[rd_addr];
        end
        if (fire && acq_ok) begin
            mask_mem[idx_reg] <= mask_reg;
            gen_mem[idx_reg]  <= gen_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg           <= s_op;
            tag_ok_reg       <= (s_handle[31:16] == HANDLE_TAG) && num_ok;
            hgen_reg         <= s_handle[15:8];
            mask_reg         <= s_mask;
            value_reg        <= s_value;
            shared_reg       <= s_shared_requested;
            lease_in_use_reg <= s_lease_in_use;
            idx_reg          <= rd_addr;
            free_found_reg   <= free_found;
        end
    end

    assign gen_cur   = gen_vld_reg[idx_reg] ? gen_rd_reg : '0;
    assign gen_inc   = gen_cur + 8'd1;
    assign gen_new   = (gen_inc == '0) ? 8'd1 : gen_inc;
    assign handle_ok = tag_ok_reg && in_use_reg[idx_reg] && (hgen_reg == gen_cur);

    always_comb begin
        status       = STAT_OK;
        acq_ok       = 1'b0;
        new_handle   = '0;
        own_next     = own_reg;
        led_next     = led_reg;
        in_use_next  = in_use_reg;
        gen_vld_next = gen_vld_reg;
        case (op_reg)
            OP_ACQUIRE: begin
                if (mask_reg == '0 || lease_in_use_reg) begin
                    status = STAT_INVALID_ARG;
                end else if (shared_reg) begin
                    status = STAT_UNSUPPORTED;
                end else if (!present_reg) begin
                    status = STAT_NOT_PRESENT;
                end else if (((own_reg | reserved_reg) & mask_reg) != '0) begin
                    status = STAT_BUSY;
                end else if (!free_found_reg) begin
                    status = STAT_NO_SLOTS;
                end else begin
                    acq_ok                = 1'b1;
                    own_next              = own_reg | mask_reg;
                    in_use_next[idx_reg]  = 1'b1;
                    gen_vld_next[idx_reg] = 1'b1;
                    new_handle            = {HANDLE_TAG, gen_new, 8'(idx_reg) + 8'd1};
                end
            end
            OP_RELEASE, OP_WRITE, OP_SET, OP_CLEAR, OP_TOGGLE: begin
                if (!handle_ok) begin
                    status = STAT_BAD_HANDLE;
                end else if (op_reg == OP_RELEASE) begin
                    own_next             = own_reg & ~mask_rd_reg;
                    in_use_next[idx_reg] = 1'b0;
                end else if (op_reg == OP_WRITE) begin
                    led_next = (led_reg & ~mask_rd_reg) | (value_reg & mask_rd_reg);
                end else if (op_reg == OP_SET) begin
                    led_next = led_reg | (mask_reg & mask_rd_reg);
                end else if (op_reg == OP_CLEAR) begin
                    led_next = led_reg & ~(mask_reg & mask_rd_reg);
                end else begin
                    led_next = led_reg ^ (mask_reg & mask_rd_reg);
                end
            end
            OP_READ: begin
                status = STAT_OK;
            end
            default: begin
                status = STAT_INVALID_ARG;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            present_reg  <= 1'b1;
            reserved_reg <= '0;
            own_reg      <= '0;
            led_reg      <= '0;
            in_use_reg   <= '0;
            gen_vld_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (fire) begin
                own_reg     <= own_next;
                led_reg     <= led_next;
                in_use_reg  <= in_use_next;
                gen_vld_reg <= gen_vld_next;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PANEL_PRESENT) begin
                    present_reg <= cfg_data[0];
                end else if (cfg_index == CFG_RESERVED_LEDS) begin
                    reserved_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_status_reg <= status;
            m_handle_reg <= new_handle;
            m_led_reg    <= led_next;
            m_own_reg    <= own_next;
        end
    end

    `LLHT_ASSERT_SAME(a_live_slot_has_gen, aclk, aresetn, 1'b1, (in_use_reg & ~gen_vld_reg) == '0)
    `LLHT_ASSERT_NEXT(a_acquire_takes_slot, aclk, aresetn, fire && acq_ok,
        $countones(in_use_reg) == $countones($past(in_use_reg)) + 1)
    `LLHT_ASSERT_NEXT(a_release_drops_leds, aclk, aresetn,
        fire && (op_reg == OP_RELEASE) && handle_ok, (own_reg & $past(mask_rd_reg)) == '0)

endmodule
